[rtl/core/multi_queue_linked_list_manager_unit_defines.svh]
// Assertion macros for the queue manager
`ifndef MULTI_QUEUE_LINKED_LIST_MANAGER_UNIT_DEFINES_SVH
`define MULTI_QUEUE_LINKED_LIST_MANAGER_UNIT_DEFINES_SVH

`define MQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mqllm_pkg.sv]
package mqllm_pkg;

   localparam int NumItems  = 64;
   localparam int NumQueues = 32;
   localparam int ItemW     = $clog2(NumItems);
   localparam int QueueW    = $clog2(NumQueues);
   localparam int LinkW     = ItemW + 1;
   localparam int QLinkW    = QueueW + 1;
   localparam int KeyW      = 16;
   localparam int StepW     = ItemW + 1;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_DISPOSE = 3'd1,
      OP_APPEND  = 3'd2,
      OP_POP     = 3'd3,
      OP_REMOVE  = 3'd4,
      OP_INSERT  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_QUEUED   = 2'd2,
      ST_NO_QUEUE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_RDHEAD,
      S_WALK_RD,
      S_WALK_CHK,
      S_UNLINK_RD,
      S_UNLINK_WR,
      S_INS_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             lt;
      logic             eq;
   } cmp_result_type;

endpackage

[rtl/core/mqllm_cmp.sv]
module mqllm_cmp (
   input  logic signed [mqllm_pkg::KeyW-1:0]  key_a,
   input  logic signed [mqllm_pkg::KeyW-1:0]  key_b,
   input  logic        [mqllm_pkg::LinkW-1:0] link_a,
   input  logic        [mqllm_pkg::LinkW-1:0] link_b,
   output mqllm_pkg::cmp_result_type          result
);

   assign result.lt = key_a < key_b;
   assign result.eq = link_a == link_b;

endmodule

[rtl/core/multi_queue_linked_list_manager_unit.sv]
// channel | dir | word fields (low bit first)
// req     | in  | tdata: opcode[2:0] queue_id[7:3] item_id[13:8] sort_key[29:14]
// rsp     | out | tdata: item_out[5:0] queue_out[10:6] status[12:11]
// Remove and insert walk the queue one entry at a time, a pace set by the
// single read port of the item link memory.
// Reset is synchronous; all queue head and tail links start null, all descriptors free.
// A result waits in its output register until taken; the next word is
// accepted meanwhile and holds in its last step while rsp stalls.
`include "multi_queue_linked_list_manager_unit_defines.svh"
module multi_queue_linked_list_manager_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // opcode, queue_id, item_id, sort_key
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // item_out, queue_out, status
);

   localparam int IW = mqllm_pkg::ItemW;
   localparam int QW = mqllm_pkg::QueueW;
   localparam int LW = mqllm_pkg::LinkW;
   localparam int QLW = mqllm_pkg::QLinkW;
   localparam int KW = mqllm_pkg::KeyW;
   localparam int NI = mqllm_pkg::NumItems;
   localparam int NQ = mqllm_pkg::NumQueues;
   localparam logic [LW-1:0] NIL = {LW{1'b1}};
   localparam logic [QLW-1:0] QNIL = {QLW{1'b1}};

   mqllm_pkg::state_type state_ff, state_in;

   logic [LW-1:0] nxt_mem [NI];
   logic [LW-1:0] prv_mem [NI];
   logic signed [KW-1:0] key_mem [NI];
   logic [NI-1:0] linked_ff;
   logic [LW-1:0] qhead_ff [NQ];
   logic [LW-1:0] qtail_ff [NQ];
   logic [QLW-1:0] qfree_ff [NQ];
   logic [NQ-1:0] qalloc_ff;
   logic [QW-1:0] ftop_ff;
   logic          fempty_ff;

   logic [2:0]    op_ff;
   logic [QW-1:0] q_ff;
   logic [IW-1:0] m_ff;
   logic signed [KW-1:0] key_ff;
   logic [LW-1:0] t_ff, prev_ff, rn_ff, rp_ff;
   logic signed [KW-1:0] tkey_ff;
   logic [mqllm_pkg::StepW-1:0] steps_ff;
   logic [IW-1:0] iout_ff;
   logic [QW-1:0] qout_ff;
   logic [1:0]    st_ff;
   logic          rvalid_ff;
   logic [12:0]   rdata_ff;

   logic [IW-1:0] rd_addr;
   mqllm_pkg::cmp_result_type cmp;

   mqllm_cmp u_cmp (
      .key_a  (tkey_ff),
      .key_b  (key_ff),
      .link_a (t_ff),
      .link_b ({1'b0, m_ff}),
      .result (cmp)
   );

   assign req_tready = (state_ff == mqllm_pkg::S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {3'b0, rdata_ff};
   assign rd_addr    = t_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqllm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mqllm_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) state_in = mqllm_pkg::S_DECODE;
         end
         mqllm_pkg::S_DECODE: begin
            state_in = mqllm_pkg::S_DONE;
            if (qalloc_ff[q_ff] && !(op_ff == mqllm_pkg::OP_ALLOC)) begin
               if (op_ff == mqllm_pkg::OP_POP) begin
                  if (!qhead_ff[q_ff][IW]) state_in = mqllm_pkg::S_UNLINK_RD;
               end else if (op_ff == mqllm_pkg::OP_REMOVE) begin
                  state_in = mqllm_pkg::S_RDHEAD;
               end else if (op_ff == mqllm_pkg::OP_INSERT && !linked_ff[m_ff]) begin
                  state_in = mqllm_pkg::S_RDHEAD;
               end
            end
         end
         mqllm_pkg::S_RDHEAD:  state_in = mqllm_pkg::S_WALK_RD;
         mqllm_pkg::S_WALK_RD: begin
            if (t_ff[IW]) begin
               state_in = (op_ff == mqllm_pkg::OP_INSERT) ? mqllm_pkg::S_INS_WR
                                                          : mqllm_pkg::S_DONE;
            end else begin
               state_in = mqllm_pkg::S_WALK_CHK;
            end
         end
         mqllm_pkg::S_WALK_CHK: begin
            if (op_ff == mqllm_pkg::OP_REMOVE) begin
               state_in = cmp.eq ? mqllm_pkg::S_UNLINK_RD : mqllm_pkg::S_WALK_RD;
            end else begin
               state_in = cmp.lt ? mqllm_pkg::S_WALK_RD : mqllm_pkg::S_INS_WR;
            end
            if (steps_ff[IW]) state_in = (op_ff == mqllm_pkg::OP_INSERT)
                                         ? mqllm_pkg::S_INS_WR : mqllm_pkg::S_DONE;
         end
         mqllm_pkg::S_UNLINK_RD: state_in = mqllm_pkg::S_UNLINK_WR;
         mqllm_pkg::S_UNLINK_WR: state_in = mqllm_pkg::S_DONE;
         mqllm_pkg::S_INS_WR:    state_in = mqllm_pkg::S_DONE;
         mqllm_pkg::S_DONE: begin
            state_in = (!rvalid_ff || rsp_tready) ? mqllm_pkg::S_IDLE : mqllm_pkg::S_DONE;
         end
         default:                state_in = mqllm_pkg::S_IDLE;
      endcase
   end

   // item memories: one read port, up to two writes a cycle each
   always_ff @(posedge clock) begin
      tkey_ff <= key_mem[rd_addr];
      rn_ff   <= nxt_mem[rd_addr];
      rp_ff   <= prv_mem[rd_addr];
      if (state_ff == mqllm_pkg::S_DECODE && op_ff == mqllm_pkg::OP_APPEND &&
          qalloc_ff[q_ff] && !linked_ff[m_ff]) begin
         nxt_mem[m_ff] <= NIL;
         prv_mem[m_ff] <= qtail_ff[q_ff];
         if (!qtail_ff[q_ff][IW]) nxt_mem[qtail_ff[q_ff][IW-1:0]] <= {1'b0, m_ff};
      end
      if (state_ff == mqllm_pkg::S_DECODE && op_ff == mqllm_pkg::OP_INSERT &&
          qalloc_ff[q_ff] && !linked_ff[m_ff]) begin
         key_mem[m_ff] <= key_ff;
      end
      if (state_ff == mqllm_pkg::S_UNLINK_WR) begin
         nxt_mem[t_ff[IW-1:0]] <= NIL;
         prv_mem[t_ff[IW-1:0]] <= NIL;
         if (!rn_ff[IW]) prv_mem[rn_ff[IW-1:0]] <= rp_ff;
         if (!rp_ff[IW]) nxt_mem[rp_ff[IW-1:0]] <= rn_ff;
      end
      if (state_ff == mqllm_pkg::S_INS_WR) begin
         prv_mem[m_ff] <= prev_ff;
         nxt_mem[m_ff] <= t_ff;
         if (!prev_ff[IW]) nxt_mem[prev_ff[IW-1:0]] <= {1'b0, m_ff};
         if (!t_ff[IW])    prv_mem[t_ff[IW-1:0]]    <= {1'b0, m_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            qhead_ff[i] <= NIL;
            qtail_ff[i] <= NIL;
            qfree_ff[i] <= (i + 1 < NQ) ? QLW'(i + 1) : QNIL;
         end
         qalloc_ff <= '0;
         linked_ff <= '0;
         ftop_ff   <= '0;
         fempty_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         if (state_ff == mqllm_pkg::S_DONE && (!rvalid_ff || rsp_tready)) begin
            rvalid_ff <= 1'b1;
            rdata_ff  <= {st_ff, qout_ff, iout_ff};
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
         case (state_ff)
            mqllm_pkg::S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  op_ff  <= req_tdata[2:0];
                  q_ff   <= req_tdata[7:3];
                  m_ff   <= req_tdata[13:8];
                  key_ff <= req_tdata[29:14];
                  iout_ff <= '0;
                  qout_ff <= '0;
                  st_ff   <= mqllm_pkg::ST_OK;
                  prev_ff <= NIL;
                  steps_ff <= '0;
               end
            end
            mqllm_pkg::S_DECODE: begin
               t_ff <= qhead_ff[q_ff];
               case (op_ff)
                  mqllm_pkg::OP_ALLOC: begin
                     if (fempty_ff) begin
                        st_ff <= mqllm_pkg::ST_NO_QUEUE;
                     end else begin
                        if (qfree_ff[ftop_ff][QW]) fempty_ff <= 1'b1;
                        else ftop_ff <= qfree_ff[ftop_ff][QW-1:0];
                        qhead_ff[ftop_ff] <= NIL;
                        qtail_ff[ftop_ff] <= NIL;
                        qalloc_ff[ftop_ff] <= 1'b1;
                        qout_ff <= ftop_ff;
                     end
                  end
                  mqllm_pkg::OP_DISPOSE: begin
                     if (qalloc_ff[q_ff]) begin
                        qfree_ff[q_ff] <= fempty_ff ? QNIL : {1'b0, ftop_ff};
                        qhead_ff[q_ff] <= NIL;
                        qtail_ff[q_ff] <= NIL;
                        ftop_ff   <= q_ff;
                        fempty_ff <= 1'b0;
                        qalloc_ff[q_ff] <= 1'b0;
                     end
                  end
                  mqllm_pkg::OP_APPEND: begin
                     if (!qalloc_ff[q_ff]) st_ff <= mqllm_pkg::ST_EMPTY;
                     else if (linked_ff[m_ff]) st_ff <= mqllm_pkg::ST_QUEUED;
                     else begin
                        if (qtail_ff[q_ff][IW]) qhead_ff[q_ff] <= {1'b0, m_ff};
                        qtail_ff[q_ff] <= {1'b0, m_ff};
                        linked_ff[m_ff] <= 1'b1;
                        iout_ff <= m_ff;
                     end
                  end
                  mqllm_pkg::OP_POP: begin
                     if (!qalloc_ff[q_ff] || qhead_ff[q_ff][IW])
                        st_ff <= mqllm_pkg::ST_EMPTY;
                  end
                  mqllm_pkg::OP_REMOVE: begin
                     if (!qalloc_ff[q_ff]) st_ff <= mqllm_pkg::ST_EMPTY;
                  end
                  mqllm_pkg::OP_INSERT: begin
                     if (!qalloc_ff[q_ff]) st_ff <= mqllm_pkg::ST_EMPTY;
                     else if (linked_ff[m_ff]) st_ff <= mqllm_pkg::ST_QUEUED;
                  end
                  default: ;
               endcase
            end
            mqllm_pkg::S_WALK_RD: begin
               if (t_ff[IW] && op_ff == mqllm_pkg::OP_REMOVE)
                  st_ff <= mqllm_pkg::ST_EMPTY;
            end
            mqllm_pkg::S_WALK_CHK: begin
               if (steps_ff[IW]) begin
                  if (op_ff == mqllm_pkg::OP_REMOVE) st_ff <= mqllm_pkg::ST_EMPTY;
               end else if (op_ff == mqllm_pkg::OP_REMOVE) begin
                  if (!cmp.eq) begin
                     t_ff <= rn_ff;
                     steps_ff <= steps_ff + 1'b1;
                  end
               end else if (cmp.lt) begin
                  prev_ff <= t_ff;
                  t_ff <= rn_ff;
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            mqllm_pkg::S_UNLINK_WR: begin
               if (rn_ff[IW]) qtail_ff[q_ff] <= rp_ff;
               if (rp_ff[IW]) qhead_ff[q_ff] <= rn_ff;
               linked_ff[t_ff[IW-1:0]] <= 1'b0;
               iout_ff <= t_ff[IW-1:0];
            end
            mqllm_pkg::S_INS_WR: begin
               if (prev_ff[IW]) qhead_ff[q_ff] <= {1'b0, m_ff};
               if (t_ff[IW])    qtail_ff[q_ff] <= {1'b0, m_ff};
               linked_ff[m_ff] <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   `MQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
   `MQ_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == mqllm_pkg::S_DONE, rsp_tvalid, "result lost")
   `MQ_ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == mqllm_pkg::S_WALK_CHK, steps_ff <= NI, "walk overran")

endmodule

[tb/sv/multi_queue_linked_list_manager_unit_tb.sv]
module multi_queue_linked_list_manager_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NQ = mqllm_pkg::NumQueues;
   localparam int NI = mqllm_pkg::NumItems;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int NIL = -1;
   localparam int RANDOM_WORDS = 1100;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [5:0] item;
      logic [4:0] queue;
      mqllm_pkg::status_type st;
   } rsp_word_type;

   typedef struct {
      logic [2:0] op;
      int q;
      int item;
      int key;
      bit typed;
      int e_item;
      int e_queue;
      mqllm_pkg::status_type e_st;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int q_head[NQ];
   int q_tail[NQ];
   bit q_alloc[NQ];
   int free_top;
   bit free_empty;
   int nxt[NI];
   int prv[NI];
   logic signed [15:0] key_of[NI];
   bit linked[NI];
   bit keyed[NI];

   rsp_word_type pending_rsp[$];
   int errors = 0;
   int cycles = 0;
   bit long_hold_done = 1'b0;
   dir_row_type dir_rows[];

   multi_queue_linked_list_manager_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("[multi_queue_linked_list_manager_unit] ERROR");
            $finish;
         end
      end
   end

   function automatic void clear_lists();
      for (int i = 0; i < NQ; i++) begin
         q_head[i] = (i + 1 < NQ) ? i + 1 : NIL;
         q_tail[i] = NIL;
         q_alloc[i] = 1'b0;
      end
      free_top = 0;
      free_empty = 1'b0;
      for (int i = 0; i < NI; i++) begin
         nxt[i] = NIL;
         prv[i] = NIL;
         key_of[i] = '0;
         linked[i] = 1'b0;
         keyed[i] = 1'b0;
      end
   endfunction

   function automatic void unlink(int q, int m);
      int n;
      int p;
      n = nxt[m];
      p = prv[m];
      if (n != NIL) prv[n] = p; else q_tail[q] = p;
      if (p != NIL) nxt[p] = n; else q_head[q] = n;
      nxt[m] = NIL;
      prv[m] = NIL;
      linked[m] = 1'b0;
   endfunction

   function automatic rsp_word_type apply_op(logic [2:0] op, int q, int m,
                                             logic signed [15:0] k);
      rsp_word_type r;
      bit qok;
      int t;
      int p;
      int steps;
      r.item = '0;
      r.queue = '0;
      r.st = mqllm_pkg::ST_OK;
      qok = q_alloc[q];
      case (op)
         mqllm_pkg::OP_ALLOC: begin
            if (free_empty) begin
               r.st = mqllm_pkg::ST_NO_QUEUE;
            end else begin
               t = free_top;
               if (q_head[t] != NIL) free_top = q_head[t]; else free_empty = 1'b1;
               q_head[t] = NIL;
               q_tail[t] = NIL;
               q_alloc[t] = 1'b1;
               r.queue = 5'(t);
            end
         end
         mqllm_pkg::OP_DISPOSE: begin
            if (qok) begin
               q_head[q] = free_empty ? NIL : free_top;
               q_tail[q] = NIL;
               free_top = q;
               free_empty = 1'b0;
               q_alloc[q] = 1'b0;
            end
         end
         mqllm_pkg::OP_APPEND: begin
            if (!qok) r.st = mqllm_pkg::ST_EMPTY;
            else if (linked[m]) r.st = mqllm_pkg::ST_QUEUED;
            else begin
               t = q_tail[q];
               prv[m] = t;
               nxt[m] = NIL;
               if (t != NIL) nxt[t] = m; else q_head[q] = m;
               q_tail[q] = m;
               linked[m] = 1'b1;
               r.item = 6'(m);
            end
         end
         mqllm_pkg::OP_POP: begin
            if (!qok || q_head[q] == NIL) r.st = mqllm_pkg::ST_EMPTY;
            else begin
               t = q_head[q];
               unlink(q, t);
               r.item = 6'(t);
            end
         end
         mqllm_pkg::OP_REMOVE: begin
            if (!qok) r.st = mqllm_pkg::ST_EMPTY;
            else begin
               t = q_head[q];
               steps = 0;
               while (t != NIL && t != m && steps < NI) begin
                  t = nxt[t];
                  steps++;
               end
               if (t != m) r.st = mqllm_pkg::ST_EMPTY;
               else begin
                  unlink(q, m);
                  r.item = 6'(m);
               end
            end
         end
         mqllm_pkg::OP_INSERT: begin
            if (!qok) r.st = mqllm_pkg::ST_EMPTY;
            else if (linked[m]) r.st = mqllm_pkg::ST_QUEUED;
            else begin
               key_of[m] = k;
               keyed[m] = 1'b1;
               p = NIL;
               t = q_head[q];
               steps = 0;
               while (t != NIL && key_of[t] < k && steps < NI) begin
                  p = t;
                  t = nxt[t];
                  steps++;
               end
               prv[m] = p;
               if (p != NIL) nxt[p] = m; else q_head[q] = m;
               nxt[m] = t;
               if (t != NIL) prv[t] = m; else q_tail[q] = m;
               linked[m] = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit all_keyed(int q);
      int t;
      int steps;
      t = q_head[q];
      steps = 0;
      while (t != NIL && steps < NI) begin
         if (!keyed[t]) return 1'b0;
         t = nxt[t];
         steps++;
      end
      return 1'b1;
   endfunction

   task automatic send_word(logic [2:0] op, int q, int m, int k, bit typed,
                            rsp_word_type typed_rsp);
      rsp_word_type r;
      @(negedge clock);
      req_tdata <= {2'b00, k[15:0], m[5:0], q[4:0], op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = apply_op(op, q, m, k[15:0]);
      pending_rsp.push_back(typed ? typed_rsp : r);
   endtask

   task automatic idle_gap(int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // receiver: stall pattern, plus one long hold-off
   initial begin
      int mode;
      int hold_at;
      mode = 0;
      hold_at = $urandom_range(500, 1500);
      forever begin
         @(negedge clock);
         if (cycles % 64 == 0) mode = $urandom_range(0, 3);
         if (!long_hold_done && cycles >= hold_at) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold_done = 1'b1;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= cycles[2];
            endcase
         end
      end
   end

   // check each taken word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected word: expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tdata[5:0] !== e.item) begin
               $display("%0t item_out: expected %0d actual %0d", $time, e.item,
                        rsp_tdata[5:0]);
               errors++;
            end
            if (rsp_tdata[10:6] !== e.queue) begin
               $display("%0t queue_out: expected %0d actual %0d", $time, e.queue,
                        rsp_tdata[10:6]);
               errors++;
            end
            if (rsp_tdata[12:11] !== e.st) begin
               $display("%0t status: expected %0d actual %0d", $time, e.st,
                        rsp_tdata[12:11]);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp_word_type tr;
      int burst;
      int phase;
      int w;
      logic [2:0] op;
      int q;
      int m;
      int k;
      int aq[$];
      int members[$];
      int t;
      dir_rows = '{
         '{mqllm_pkg::OP_ALLOC,    0,  0,      0, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_POP,      0,  0,      0, 1,  0, 0, mqllm_pkg::ST_EMPTY},
         '{mqllm_pkg::OP_APPEND,   0, 63,      0, 1, 63, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_APPEND,   0, 63,      0, 1,  0, 0, mqllm_pkg::ST_QUEUED},
         '{mqllm_pkg::OP_APPEND,   5,  1,      0, 1,  0, 0, mqllm_pkg::ST_EMPTY},
         '{mqllm_pkg::OP_REMOVE,   0,  0,      0, 1,  0, 0, mqllm_pkg::ST_EMPTY},
         '{mqllm_pkg::OP_INSERT,   1,  2,      0, 1,  0, 0, mqllm_pkg::ST_EMPTY},
         '{mqllm_pkg::OP_POP,      0,  0,      0, 1, 63, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_INSERT,   0,  0,  32767, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_INSERT,   0,  1, -32768, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_INSERT,   0,  2,      0, 0,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_INSERT,   0,  0,      5, 1,  0, 0, mqllm_pkg::ST_QUEUED},
         '{mqllm_pkg::OP_REMOVE,   0,  2,      0, 0,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_REMOVE,   0,  0,      0, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_POP,      0,  0,      0, 1,  1, 0, mqllm_pkg::ST_OK},
         '{OP_SPARE_LO,           31, 63,     -1, 1,  0, 0, mqllm_pkg::ST_OK},
         '{OP_SPARE_HI,           31, 63,     -1, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_DISPOSE, 31,  0,      0, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_ALLOC,    0,  0,      0, 1,  0, 1, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_APPEND,   1, 62,      0, 1, 62, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_DISPOSE,  1,  0,      0, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_APPEND,   0, 62,      0, 1,  0, 0, mqllm_pkg::ST_QUEUED},
         '{mqllm_pkg::OP_DISPOSE,  0,  0,      0, 1,  0, 0, mqllm_pkg::ST_OK},
         '{mqllm_pkg::OP_ALLOC,    0,  0,      0, 0,  0, 0, mqllm_pkg::ST_OK}
      };
      clear_lists();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         tr.item = 6'(dir_rows[i].e_item);
         tr.queue = 5'(dir_rows[i].e_queue);
         tr.st = dir_rows[i].e_st;
         send_word(dir_rows[i].op, dir_rows[i].q, dir_rows[i].item, dir_rows[i].key,
                   dir_rows[i].typed, tr);
      end

      burst = 0;
      phase = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 150 == 0) phase = $urandom_range(0, 2);
         aq.delete();
         for (int i = 0; i < NQ; i++) if (q_alloc[i]) aq.push_back(i);
         w = $urandom_range(0, 99);
         if (phase == 1 && w < 35) op = mqllm_pkg::OP_ALLOC;
         else if (phase == 2 && w < 25) op = mqllm_pkg::OP_DISPOSE;
         else begin
            w = $urandom_range(0, 99);
            if (w < 10) op = mqllm_pkg::OP_ALLOC;
            else if (w < 17) op = mqllm_pkg::OP_DISPOSE;
            else if (w < 42) op = mqllm_pkg::OP_APPEND;
            else if (w < 62) op = mqllm_pkg::OP_POP;
            else if (w < 78) op = mqllm_pkg::OP_REMOVE;
            else if (w < 97) op = mqllm_pkg::OP_INSERT;
            else op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
         end
         if (aq.size() > 0 && $urandom_range(0, 9) != 0)
            q = aq[$urandom_range(0, aq.size() - 1)];
         else q = $urandom_range(0, NQ - 1);
         m = $urandom_range(0, NI - 1);
         k = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 8) - 4;
         // keep most disposes on empty queues so items do not leak
         if (op == mqllm_pkg::OP_DISPOSE && q_head[q] != NIL && q_alloc[q] &&
             $urandom_range(0, 19) != 0)
            op = mqllm_pkg::OP_POP;
         if (op == mqllm_pkg::OP_REMOVE && q_alloc[q] && $urandom_range(0, 9) < 7) begin
            members.delete();
            t = q_head[q];
            while (t != NIL && members.size() < NI) begin
               members.push_back(t);
               t = nxt[t];
            end
            if (members.size() > 0) m = members[$urandom_range(0, members.size() - 1)];
         end
         if (op == mqllm_pkg::OP_INSERT && q_alloc[q] && !linked[m] && !all_keyed(q))
            op = mqllm_pkg::OP_APPEND;
         if (burst == 0) begin
            burst = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
         end
         burst--;
         send_word(op, q, m, k, 1'b0, tr);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[multi_queue_linked_list_manager_unit] OK");
      end else begin
         $display("[multi_queue_linked_list_manager_unit] ERROR");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/mqllm_pkg.sv
rtl/core/mqllm_cmp.sv
rtl/core/multi_queue_linked_list_manager_unit.sv
tb/sv/multi_queue_linked_list_manager_unit_tb.sv
